// File: sv/jsu_pkg.sv
// Package for the JSON string unescaper: types, codes, character constants, helpers.
package jsu_pkg;

	// Decoder mode, one-hot
	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_ESCAPE = 3'b010,
		MODE_HEX    = 3'b100
	} mode_t;

	// Result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_END    = 2'd1;
	localparam logic [1:0] KIND_UNTERM = 2'd2;
	localparam logic [1:0] KIND_BADHEX = 2'd3;

	// Characters of interest
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_A     = 8'h61;

	// Decoder state
	typedef struct packed {
		mode_t       mode;
		logic [1:0]  digits;
		logic [11:0] acc;
	} dec_state_t;

	// One result item
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
	} result_t;

	// All results of one request, res[0] goes out first
	typedef struct packed {
		logic [1:0]         cnt;
		result_t [2:0]      res;
	} bundle_t;

	// Hex digit decode: {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// File: sv/jsu_decode.sv
// Combinational decoder: current state and one input byte to next state and results.
module jsu_decode (
	input  jsu_pkg::dec_state_t cur,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output jsu_pkg::dec_state_t nxt,
	output jsu_pkg::bundle_t    bnd
);

	logic [4:0]  hex;
	logic [15:0] cp;
	logic [7:0]  esc_byte;
	logic        esc_known;

	assign hex = jsu_pkg::hex_digit(in_byte);
	assign cp  = {cur.acc, hex[3:0]};

	// Single-character escapes
	always_comb begin
		esc_known = 1'b1;
		case (in_byte)
			jsu_pkg::CH_SLASH: esc_byte = jsu_pkg::CH_SLASH;
			jsu_pkg::CH_BSL:   esc_byte = jsu_pkg::CH_BSL;
			jsu_pkg::CH_B:     esc_byte = 8'h08;
			jsu_pkg::CH_F:     esc_byte = 8'h0C;
			jsu_pkg::CH_R:     esc_byte = 8'h0D;
			jsu_pkg::CH_N:     esc_byte = 8'h0A;
			jsu_pkg::CH_T:     esc_byte = 8'h09;
			jsu_pkg::CH_V:     esc_byte = 8'h0B;
			jsu_pkg::CH_A:     esc_byte = 8'h07;
			default: begin
				esc_byte  = jsu_pkg::CH_BSL;
				esc_known = 1'b0;
			end
		endcase
	end

	// Mode handling
	always_comb begin
		nxt.mode   = jsu_pkg::MODE_NORMAL;
		nxt.digits = 2'd0;
		nxt.acc    = 12'd0;
		bnd.cnt    = 2'd0;
		bnd.res[0] = '{data: 8'd0, kind: jsu_pkg::KIND_DATA};
		bnd.res[1] = '{data: 8'd0, kind: jsu_pkg::KIND_DATA};
		bnd.res[2] = '{data: 8'd0, kind: jsu_pkg::KIND_DATA};
		case (cur.mode)
			jsu_pkg::MODE_ESCAPE: begin
				if (in_last) begin
					bnd.cnt         = 2'd1;
					bnd.res[0].kind = jsu_pkg::KIND_UNTERM;
				end else if (in_byte == jsu_pkg::CH_U) begin
					nxt.mode = jsu_pkg::MODE_HEX;
				end else if (esc_known) begin
					bnd.cnt         = 2'd1;
					bnd.res[0].data = esc_byte;
				end else begin
					// unknown escape keeps the backslash
					bnd.cnt         = 2'd2;
					bnd.res[0].data = jsu_pkg::CH_BSL;
					bnd.res[1].data = in_byte;
				end
			end
			jsu_pkg::MODE_HEX: begin
				if (in_last) begin
					bnd.cnt         = 2'd1;
					bnd.res[0].kind = jsu_pkg::KIND_UNTERM;
				end else if (!hex[4]) begin
					bnd.cnt         = 2'd1;
					bnd.res[0].kind = jsu_pkg::KIND_BADHEX;
				end else if (cur.digits == 2'd3) begin
					// UTF-8 encode the code point
					if (cp <= 16'h007F) begin
						bnd.cnt         = 2'd1;
						bnd.res[0].data = cp[7:0];
					end else if (cp <= 16'h07FF) begin
						bnd.cnt         = 2'd2;
						bnd.res[0].data = {3'b110, cp[10:6]};
						bnd.res[1].data = {2'b10, cp[5:0]};
					end else begin
						bnd.cnt         = 2'd3;
						bnd.res[0].data = {4'hE, cp[15:12]};
						bnd.res[1].data = {2'b10, cp[11:6]};
						bnd.res[2].data = {2'b10, cp[5:0]};
					end
				end else begin
					nxt.mode   = jsu_pkg::MODE_HEX;
					nxt.digits = cur.digits + 2'd1;
					nxt.acc    = {cur.acc[7:0], hex[3:0]};
				end
			end
			default: begin
				if (in_byte == jsu_pkg::CH_QUOTE) begin
					bnd.cnt         = 2'd1;
					bnd.res[0].kind = jsu_pkg::KIND_END;
				end else if (in_last) begin
					bnd.cnt         = 2'd1;
					bnd.res[0].kind = jsu_pkg::KIND_UNTERM;
				end else if (in_byte == jsu_pkg::CH_BSL) begin
					nxt.mode = jsu_pkg::MODE_ESCAPE;
				end else begin
					bnd.cnt         = 2'd1;
					bnd.res[0].data = in_byte;
				end
			end
		endcase
	end

endmodule

// File: sv/jsu_serial.sv
// Result register: holds one request's results and sends them one per cycle while m_tready is high.
module jsu_serial (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  jsu_pkg::bundle_t bnd,
	output logic             free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // out_byte[7:0]
	output logic [1:0]       m_tuser,   // out_kind[1:0]
	output logic             m_tlast    // out_last
);

	jsu_pkg::bundle_t bnd_q;
	logic             valid_q;
	logic [1:0]       idx_q;
	jsu_pkg::result_t cur;
	logic             at_end;

	assign cur      = bnd_q.res[idx_q];
	assign at_end   = idx_q == (bnd_q.cnt - 2'd1);
	assign m_tvalid = valid_q;
	assign m_tdata  = cur.data;
	assign m_tuser  = cur.kind;
	assign m_tlast  = at_end;
	// can take new results once the last one held is leaving
	assign free     = !valid_q || (m_tready && at_end);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (valid_q && m_tready) begin
			if (at_end) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			bnd_q <= bnd;
		end
	end

endmodule

// File: sv/json_string_unescape_utf8.sv
// Latency: the first result of a request is offered the cycle after it is accepted.
// Throughput: one request per cycle while each makes at most one result and m_tready is high; a
// request with more results holds the input until its last result leaves, one sent per ready cycle.
// Requests with no result (backslash, u, first hex digits) also wait while the output is busy.
// Reset clears the decoder to normal text mode and empties the result register.
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte[7:0]
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte[7:0]
	output logic [1:0] m_tuser,   // out_kind[1:0]
	output logic       m_tlast    // out_last
);

	jsu_pkg::dec_state_t st_q;
	jsu_pkg::dec_state_t st_nxt;
	jsu_pkg::bundle_t    bnd;
	logic                free;
	logic                s_acc;
	logic                load;

	assign s_tready = free;
	assign s_acc    = s_tvalid && s_tready;
	assign load     = s_acc && (bnd.cnt != 2'd0);

	jsu_decode u_dec (
		.cur     (st_q),
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.nxt     (st_nxt),
		.bnd     (bnd)
	);

	jsu_serial u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.bnd      (bnd),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode   <= jsu_pkg::MODE_NORMAL;
			st_q.digits <= 2'd0;
			st_q.acc    <= 12'd0;
		end else if (s_acc) begin
			st_q <= st_nxt;
		end
	end

	// A marker or error result always closes its request
	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != jsu_pkg::KIND_DATA) |-> m_tlast)
		else $error("marker result not flagged last");

	// A byte flagged last always leaves the decoder in normal mode
	a_last_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tlast) |=> (st_q.mode == jsu_pkg::MODE_NORMAL))
		else $error("decoder not in normal mode after last byte");

	// Read index stays within the held results
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (u_ser.idx_q < u_ser.bnd_q.cnt))
		else $error("result index beyond held count");

endmodule
